>>> hw/rtl/bef_pkg.sv
// ----------------------------------------------------------------------------
// bef_pkg
// Shared codes and widths for the box exit face and time unit.
// ----------------------------------------------------------------------------
package bef_pkg;

   localparam int NUM_FACES = 6;
   localparam int FACE_BITS = 3;
   localparam int TOL_BITS  = 31;

   localparam logic [FACE_BITS-1:0] FACE_NONE = 3'd6;

   typedef enum logic [1:0] {
      OUTCOME_CROSS   = 2'd0,
      OUTCOME_ON_FACE = 2'd1,
      OUTCOME_NONE    = 2'd2
   } outcome_type;

endpackage

>>> hw/rtl/bef_divider.sv
// ----------------------------------------------------------------------------
// bef_divider
// Pipelined restoring divider: quo = sat(num * 2^FB / den), one quotient bit
// per stage, QB + 1 register stages.
// ----------------------------------------------------------------------------
module bef_divider #(
   parameter int QB = 32,
   parameter int FB = 16
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [QB:0]   num,
   input  logic [QB-1:0] den,
   output logic [QB-1:0] quo
);
   import bef_pkg::*;

   localparam int DW = QB + 1 + FB;
   localparam int SW = 2 * QB + FB + 1;

   logic [DW-1:0] d_full;
   logic [DW-1:0] d_hi;
   logic          sat_w;

   logic [QB-1:0] r_ff   [QB+1];
   logic [QB-1:0] lo_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [QB-1:0] den_ff [QB+1];
   logic          sat_ff [QB+1];

   logic [QB-1:0] r_in  [QB+1];
   logic [QB-1:0] q_in  [QB+1];

   always_comb begin
      d_full = {num, {FB{1'b0}}};
      d_hi   = d_full >> QB;
      // quotient would not fit in QB bits
      sat_w  = (SW'(num) << FB) >= (SW'(den) << QB);
   end

   always_comb begin
      logic [QB:0] t;
      logic        ge;
      r_in[0] = d_hi[QB-1:0];
      q_in[0] = '0;
      for (int k = 1; k <= QB; k++) begin
         t  = {r_ff[k-1], lo_ff[k-1][QB-1]};
         ge = t >= {1'b0, den_ff[k-1]};
         if (ge) begin
            r_in[k] = QB'(t - {1'b0, den_ff[k-1]});
         end else begin
            r_in[k] = t[QB-1:0];
         end
         q_in[k] = {q_ff[k-1][QB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff[0]   <= r_in[0];
         q_ff[0]   <= q_in[0];
         lo_ff[0]  <= d_full[QB-1:0];
         den_ff[0] <= den;
         sat_ff[0] <= sat_w;
         for (int k = 1; k <= QB; k++) begin
            r_ff[k]   <= r_in[k];
            q_ff[k]   <= q_in[k];
            lo_ff[k]  <= lo_ff[k-1] << 1;
            den_ff[k] <= den_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign quo = sat_ff[QB] ? {QB{1'b1}} : q_ff[QB];

endmodule

>>> hw/rtl/box_exit_face_time_unit.sv
// ----------------------------------------------------------------------------
// box_exit_face_time_unit
// Exit face and flight time of a point inside an axis-aligned box.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   pos, size, vel (x,y,z), skip_face
//  rsp      out        rsp_valid/rsp_stall   hit_face, flight_time, outcome
//  csr      in         csr_write_enable      edge_tolerance
//
// One item per cycle unless a stalled result holds the pipe. Stages: prep,
// the six bit-per-stage dividers (COORD_BITS + 1 stages), multiply, bounds
// check and output. Reset is synchronous and clears the valid bits and sets
// edge_tolerance to 1. A stalled result freezes the whole pipe.
// ----------------------------------------------------------------------------
module box_exit_face_time_unit #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bef_pkg::TOL_BITS-1:0]  csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic signed [COORD_BITS-1:0]  req_pos_z,
   input  logic [COORD_BITS-2:0]         req_size_x,
   input  logic [COORD_BITS-2:0]         req_size_y,
   input  logic [COORD_BITS-2:0]         req_size_z,
   input  logic signed [COORD_BITS-1:0]  req_vel_x,
   input  logic signed [COORD_BITS-1:0]  req_vel_y,
   input  logic signed [COORD_BITS-1:0]  req_vel_z,
   input  logic [bef_pkg::FACE_BITS-1:0] req_skip_face,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bef_pkg::FACE_BITS-1:0] rsp_hit_face,
   output logic [COORD_BITS-1:0]         rsp_flight_time,
   output bef_pkg::outcome_type          rsp_outcome
);
   import bef_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int DL  = C + 1;
   localparam int PW  = 2 * C;
   localparam int TW  = C + F + 3;
   localparam int TLW = (C + 1 > TOL_BITS) ? C + 1 : TOL_BITS;

   logic advance;
   logic [TOL_BITS-1:0] tol_ff;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_BITS'(1);
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   // ---------------- prep stage ----------------
   logic signed [C-1:0] pos_w [3];
   logic signed [C-1:0] vel_w [3];
   logic [C-2:0]        siz_w [3];
   logic [C:0]          nmag_w [NUM_FACES];
   logic [C-1:0]        vmag_w [3];
   logic [NUM_FACES-1:0] elig_w;
   logic [FACE_BITS-1:0] tface_w;
   logic                 thit_w;

   always_comb begin
      logic signed [C:0] num;
      logic signed [C:0] dif;
      logic [C:0]        dmag;
      logic [C-1:0]      pmag;
      int                a;
      pos_w[0] = req_pos_x;  pos_w[1] = req_pos_y;  pos_w[2] = req_pos_z;
      vel_w[0] = req_vel_x;  vel_w[1] = req_vel_y;  vel_w[2] = req_vel_z;
      siz_w[0] = req_size_x; siz_w[1] = req_size_y; siz_w[2] = req_size_z;
      for (int i = 0; i < 3; i++) begin
         vmag_w[i] = vel_w[i][C-1] ? C'(-vel_w[i]) : C'(vel_w[i]);
      end
      for (int f = 0; f < NUM_FACES; f++) begin
         a = f >> 1;
         if (f % 2 == 1) begin
            num = signed'({2'b00, siz_w[a]}) - {pos_w[a][C-1], pos_w[a]};
         end else begin
            num = -{pos_w[a][C-1], pos_w[a]};
         end
         nmag_w[f] = num[C] ? (C+1)'(-num) : (C+1)'(num);
         elig_w[f] = (req_skip_face != FACE_BITS'(f)) && (vel_w[a] != '0) &&
                     (num != '0) && (num[C] == vel_w[a][C-1]);
      end
      // tolerance check: reversed loop so x and min faces win
      tface_w = FACE_NONE;
      thit_w  = 1'b0;
      for (int i = 2; i >= 0; i--) begin
         dif  = {pos_w[i][C-1], pos_w[i]} - signed'({2'b00, siz_w[i]});
         dmag = dif[C] ? (C+1)'(-dif) : (C+1)'(dif);
         pmag = pos_w[i][C-1] ? C'(-pos_w[i]) : C'(pos_w[i]);
         if (TLW'(dmag) < TLW'(tol_ff)) begin
            tface_w = FACE_BITS'(2 * i + 1);
            thit_w  = 1'b1;
         end
         if (TLW'(pmag) < TLW'(tol_ff)) begin
            tface_w = FACE_BITS'(2 * i);
            thit_w  = 1'b1;
         end
      end
   end

   logic                 p_vld_ff;
   logic signed [C-1:0]  p_pos_ff  [3];
   logic signed [C-1:0]  p_vel_ff  [3];
   logic [C-2:0]         p_siz_ff  [3];
   logic [C:0]           p_nmag_ff [NUM_FACES];
   logic [C-1:0]         p_vmag_ff [3];
   logic [NUM_FACES-1:0] p_elig_ff;
   logic [FACE_BITS-1:0] p_tface_ff;
   logic                 p_thit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (advance) begin
         p_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_pos_ff   <= pos_w;
         p_vel_ff   <= vel_w;
         p_siz_ff   <= siz_w;
         p_nmag_ff  <= nmag_w;
         p_vmag_ff  <= vmag_w;
         p_elig_ff  <= elig_w;
         p_tface_ff <= tface_w;
         p_thit_ff  <= thit_w;
      end
   end

   // ---------------- dividers and side line ----------------
   logic [C-1:0] quo_w [NUM_FACES];

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_div
      bef_divider #(.QB(C), .FB(F)) u_div (
         .clock   (clock),
         .advance (advance),
         .num     (p_nmag_ff[f]),
         .den     (p_vmag_ff[f >> 1]),
         .quo     (quo_w[f])
      );
   end

   logic                 s_vld_ff   [DL];
   logic signed [C-1:0]  s_pos_ff   [DL][3];
   logic signed [C-1:0]  s_vel_ff   [DL][3];
   logic [C-2:0]         s_siz_ff   [DL][3];
   logic [NUM_FACES-1:0] s_elig_ff  [DL];
   logic [FACE_BITS-1:0] s_tface_ff [DL];
   logic                 s_thit_ff  [DL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) begin
            s_vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         s_vld_ff[0] <= p_vld_ff;
         for (int k = 1; k < DL; k++) begin
            s_vld_ff[k] <= s_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_pos_ff[0]   <= p_pos_ff;
         s_vel_ff[0]   <= p_vel_ff;
         s_siz_ff[0]   <= p_siz_ff;
         s_elig_ff[0]  <= p_elig_ff;
         s_tface_ff[0] <= p_tface_ff;
         s_thit_ff[0]  <= p_thit_ff;
         for (int k = 1; k < DL; k++) begin
            s_pos_ff[k]   <= s_pos_ff[k-1];
            s_vel_ff[k]   <= s_vel_ff[k-1];
            s_siz_ff[k]   <= s_siz_ff[k-1];
            s_elig_ff[k]  <= s_elig_ff[k-1];
            s_tface_ff[k] <= s_tface_ff[k-1];
            s_thit_ff[k]  <= s_thit_ff[k-1];
         end
      end
   end

   // ---------------- multiply stage ----------------
   logic [PW-1:0] prod_w [NUM_FACES][2];
   logic [NUM_FACES-1:0] ok_w;

   always_comb begin
      logic [C-1:0] vm;
      int a, o;
      for (int f = 0; f < NUM_FACES; f++) begin
         a = f >> 1;
         ok_w[f] = s_elig_ff[DL-1][f] && (quo_w[f] != '0);
         for (int j = 0; j < 2; j++) begin
            if (j == 0) begin
               o = (a == 0) ? 1 : 0;
            end else begin
               o = (a == 2) ? 1 : 2;
            end
            vm = s_vel_ff[DL-1][o][C-1] ? C'(-s_vel_ff[DL-1][o]) : C'(s_vel_ff[DL-1][o]);
            prod_w[f][j] = PW'(vm) * PW'(quo_w[f]);
         end
      end
   end

   logic                 m_vld_ff;
   logic [PW-1:0]        m_prod_ff  [NUM_FACES][2];
   logic [C-1:0]         m_q_ff     [NUM_FACES];
   logic [NUM_FACES-1:0] m_ok_ff;
   logic signed [C-1:0]  m_pos_ff   [3];
   logic [C-2:0]         m_siz_ff   [3];
   logic [2:0]           m_vneg_ff;
   logic [FACE_BITS-1:0] m_tface_ff;
   logic                 m_thit_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m_prod_ff  <= prod_w;
         m_q_ff     <= quo_w;
         m_ok_ff    <= ok_w;
         m_pos_ff   <= s_pos_ff[DL-1];
         m_siz_ff   <= s_siz_ff[DL-1];
         for (int i = 0; i < 3; i++) begin
            m_vneg_ff[i] <= s_vel_ff[DL-1][i][C-1];
         end
         m_tface_ff <= s_tface_ff[DL-1];
         m_thit_ff  <= s_thit_ff[DL-1];
      end
   end

   // ---------------- bounds check stage ----------------
   logic [NUM_FACES-1:0] win_w;

   always_comb begin
      logic signed [TW-1:0] scaled, lim, pt, t;
      logic                 over;
      logic [1:0]           inb;
      int a, o;
      for (int f = 0; f < NUM_FACES; f++) begin
         a = f >> 1;
         for (int j = 0; j < 2; j++) begin
            if (j == 0) begin
               o = (a == 0) ? 1 : 0;
            end else begin
               o = (a == 2) ? 1 : 2;
            end
            over   = (m_prod_ff[f][j] >> (C + F + 1)) != '0;
            scaled = TW'(m_pos_ff[o]) <<< F;
            lim    = signed'(TW'(m_siz_ff[o])) <<< F;
            pt     = signed'(TW'(m_prod_ff[f][j]));
            t      = m_vneg_ff[o] ? scaled - pt : scaled + pt;
            inb[j] = !over && (t >= 0) && (t <= lim);
         end
         win_w[f] = m_ok_ff[f] && inb[0] && inb[1];
      end
   end

   logic                 i_vld_ff;
   logic [NUM_FACES-1:0] i_win_ff;
   logic [C-1:0]         i_q_ff [NUM_FACES];
   logic [FACE_BITS-1:0] i_tface_ff;
   logic                 i_thit_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         i_win_ff   <= win_w;
         i_q_ff     <= m_q_ff;
         i_tface_ff <= m_tface_ff;
         i_thit_ff  <= m_thit_ff;
      end
   end

   // ---------------- output stage ----------------
   logic [FACE_BITS-1:0] face_w;
   logic [C-1:0]         time_w;
   outcome_type          outc_w;

   always_comb begin
      if (i_thit_ff) begin
         face_w = i_tface_ff;
         outc_w = OUTCOME_ON_FACE;
      end else begin
         face_w = FACE_NONE;
         outc_w = OUTCOME_NONE;
      end
      time_w = '0;
      // lowest winning face takes priority
      for (int f = NUM_FACES - 1; f >= 0; f--) begin
         if (i_win_ff[f]) begin
            face_w = FACE_BITS'(f);
            time_w = i_q_ff[f];
            outc_w = OUTCOME_CROSS;
         end
      end
   end

   logic                 o_vld_ff;
   logic [FACE_BITS-1:0] o_face_ff;
   logic [C-1:0]         o_time_ff;
   outcome_type          o_outc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (advance) begin
         m_vld_ff <= s_vld_ff[DL-1];
         i_vld_ff <= m_vld_ff;
         o_vld_ff <= i_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_face_ff <= face_w;
         o_time_ff <= time_w;
         o_outc_ff <= outc_w;
      end
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_hit_face    = o_face_ff;
   assign rsp_flight_time = o_time_ff;
   assign rsp_outcome     = o_outc_ff;

endmodule

>>> dv/bef_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bef_checker
// Watches the request and response channels of the box exit face unit,
// predicts the exit face, flight time and outcome of every accepted item and
// compares each response against the oldest prediction in order.
// ----------------------------------------------------------------------------
module bef_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bef_pkg::TOL_BITS-1:0]  csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [31:0]            req_pos_z,
   input  logic [30:0]                   req_size_x,
   input  logic [30:0]                   req_size_y,
   input  logic [30:0]                   req_size_z,
   input  logic signed [31:0]            req_vel_x,
   input  logic signed [31:0]            req_vel_y,
   input  logic signed [31:0]            req_vel_z,
   input  logic [bef_pkg::FACE_BITS-1:0] req_skip_face,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [bef_pkg::FACE_BITS-1:0] rsp_hit_face,
   input  logic [31:0]                   rsp_flight_time,
   input  bef_pkg::outcome_type          rsp_outcome,
   output int                            error_count,
   output int                            pending_count,
   output int                            exit_count,
   output int                            on_face_count,
   output int                            none_count
);
   import bef_pkg::*;

   typedef struct packed {
      logic [FACE_BITS-1:0] face;
      logic [31:0]          flight;
      outcome_type          outcome;
   } exit_answer_type;

   exit_answer_type exit_queue[$];
   logic [30:0]     tolerance;

   function automatic logic [63:0] abs64(longint n);
      return n < 0 ? 64'(-n) : 64'(n);
   endfunction

   // coordinate at time q stays within [0, size], bounds included
   function automatic bit within_slab(longint p, longint v, longint s, logic [63:0] q);
      logic [63:0] prod;
      longint      t;
      prod = abs64(v) * q;
      if (prod >= (64'd1 << 49)) return 0;
      t = v < 0 ? (p <<< 16) - longint'(prod) : (p <<< 16) + longint'(prod);
      return t >= 0 && t <= (s <<< 16);
   endfunction

   function automatic exit_answer_type predict_exit(longint pos[3], longint siz[3],
                                                    longint vel[3], logic [2:0] skip,
                                                    logic [30:0] tol);
      exit_answer_type r;
      longint          num;
      logic [63:0]     q;
      int              a, o1, o2;
      for (int f = 0; f < NUM_FACES; f++) begin
         a = f / 2;
         if (f == skip || vel[a] == 0) continue;
         num = ((f % 2) ? siz[a] : 0) - pos[a];
         if (num == 0 || ((num < 0) != (vel[a] < 0))) continue;
         q = (abs64(num) << 16) / abs64(vel[a]);
         if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
         if (q == 0) continue;
         o1 = (a == 0) ? 1 : 0;
         o2 = (a == 2) ? 1 : 2;
         if (within_slab(pos[o1], vel[o1], siz[o1], q) &&
             within_slab(pos[o2], vel[o2], siz[o2], q)) begin
            r.face = 3'(f); r.flight = q[31:0]; r.outcome = OUTCOME_CROSS;
            return r;
         end
      end
      for (int k = 0; k < 3; k++) begin
         r.flight = '0; r.outcome = OUTCOME_ON_FACE;
         if (abs64(pos[k]) < 64'(tol)) begin
            r.face = 3'(2 * k); return r;
         end
         if (abs64(pos[k] - siz[k]) < 64'(tol)) begin
            r.face = 3'(2 * k + 1); return r;
         end
      end
      r.face = FACE_NONE; r.flight = '0; r.outcome = OUTCOME_NONE;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      longint          p[3], s[3], v[3];
      exit_answer_type e;
      if (reset) begin
         tolerance <= 31'd1;
         error_count = 0; exit_count = 0; on_face_count = 0; none_count = 0;
         exit_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            p = '{req_pos_x, req_pos_y, req_pos_z};
            s = '{req_size_x, req_size_y, req_size_z};
            v = '{req_vel_x, req_vel_y, req_vel_z};
            exit_queue.push_back(predict_exit(p, s, v, req_skip_face, tolerance));
         end
         if (rsp_valid && !rsp_stall) begin
            if (exit_queue.size() == 0) begin
               $display("%0t: response with no item outstanding", $time);
               error_count++;
            end else begin
               e = exit_queue.pop_front();
               if (rsp_hit_face !== e.face) report_mismatch("hit_face", rsp_hit_face, e.face);
               if (rsp_flight_time !== e.flight)
                  report_mismatch("flight_time", rsp_flight_time, e.flight);
               if (rsp_outcome !== e.outcome)
                  report_mismatch("outcome", rsp_outcome, e.outcome);
               case (e.outcome)
                  OUTCOME_CROSS:   exit_count++;
                  OUTCOME_ON_FACE: on_face_count++;
                  default:         none_count++;
               endcase
            end
         end
         if (csr_write_enable) tolerance <= csr_write_data;
      end
      pending_count = exit_queue.size();
   end

endmodule

>>> dv/tb_box_exit_face_time_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_exit_face_time_unit
// Drives directed and random rays through the box exit face unit under
// random gaps and stalls across several tolerance settings; bef_checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_box_exit_face_time_unit;
   import bef_pkg::*;

   localparam int LATENCY = 32 + 5;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [TOL_BITS-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic [30:0] req_size_x = 0, req_size_y = 0, req_size_z = 0;
   logic signed [31:0] req_vel_x = 0, req_vel_y = 0, req_vel_z = 0;
   logic [2:0] req_skip_face = 3'd6;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_hit_face;
   logic [31:0] rsp_flight_time;
   outcome_type rsp_outcome;
   int error_count, pending_count, exit_count, on_face_count, none_count;
   int sent_count = 0;
   bit stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   box_exit_face_time_unit u_dut (.*);
   bef_checker u_checker (.*);

   function automatic int gap_length();
      if ($urandom_range(99) < 50) return 0;
      if ($urandom_range(99) < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(20, 0) << 16;
         2: return 32'($signed(-$urandom_range(20, 0)) <<< 16);
         3: return {$urandom} % (32'd1 << $urandom_range(31));
         4: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom_range(4, 0);
      endcase
   endfunction

   // valid stays high after an accept unless a gap follows
   task automatic send_ray(logic [31:0] px, py, pz, logic [30:0] sx, sy, sz,
                           logic [31:0] vx, vy, vz, logic [2:0] skip);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_size_x <= sx; req_size_y <= sy; req_size_z <= sz;
      req_vel_x <= vx; req_vel_y <= vy; req_vel_z <= vz;
      req_skip_face <= skip; req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // point within a box (bounds included) with random velocity, plus noise items
   task automatic send_random_ray();
      logic [30:0] sz[3];
      logic [31:0] p[3];
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(9) < 7) begin
            sz[k] = 31'($urandom_range(64, 0) << 16) |
                    31'($urandom_range(3) == 0 ? $urandom_range(65535) : 0);
            p[k] = $urandom_range(3) == 0 ? rand_coord() : 32'($urandom_range(sz[k], 0));
         end else begin
            sz[k] = 31'($urandom);
            p[k] = rand_coord();
         end
      end
      send_ray(p[0], p[1], p[2], sz[0], sz[1], sz[2],
               rand_coord(), rand_coord(), rand_coord(), 3'($urandom_range(7)));
   endtask

   task automatic write_tolerance(logic [30:0] value);
      req_valid <= 0;
      wait (pending_count == 0);
      repeat (LATENCY + 2) @(negedge clock);
      csr_write_data <= value; csr_write_enable <= 1;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: a ray toward each face with that face skipped, other skip codes, on-face, no face, extremes
      for (int f = 0; f < 8; f++)
         send_ray(32'h1_0000, 32'h1_0000, 32'h1_0000, 31'h2_0000, 31'h2_0000, 31'h2_0000,
                  f == 0 ? -32'sh1_0000 : (f == 1 ? 32'h1_0000 : 0),
                  f == 2 ? -32'sh1_0000 : (f == 3 ? 32'h1_0000 : 0),
                  f == 4 ? -32'sh1_0000 : (f == 5 ? 32'h1_0000 : 0), 3'(f));
      send_ray(0, 32'h1_0000, 32'h1_0000, 31'h2_0000, 31'h2_0000, 31'h2_0000, -32'sd1, 0, 0, 3'd0);
      send_ray(32'h2_0000, 0, 5, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0, 0, 0, 3'd6);
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
               31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 3'd6);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0,
               32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd7);
      send_ray(32'h8000, 32'h8000, 32'h8000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
               1, 1, 1, 3'd6);
      send_ray(32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 1, 1, 1, 3'd6);
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_tolerance(31'd0);
            1: write_tolerance(31'h7FFF_FFFF);
            2: write_tolerance(31'h8000);
            3: write_tolerance(31'($urandom));
            default: write_tolerance(31'd1);
         endcase
         for (int i = 0; i < 200; i++) send_random_ray();
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      int stall_len;
      @(negedge clock);
      forever begin
         stall_len = gap_length();
         if (stall_len > 0) begin
            rsp_stall <= 1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(12, 1)) @(negedge clock);
      end
   end

   initial begin
      wait (stim_done && pending_count == 0);
      repeat (LATENCY * 2) @(posedge clock);
      $display("Sent %0d rays over five tolerance settings: %0d exits, %0d on face, %0d none.",
               sent_count, exit_count, on_face_count, none_count);
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d items outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
